/* design/sfla_pkg.sv */
`default_nettype none
package sfla_pkg;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;
  localparam int AW = 21;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POP, S_DIV, S_PUSHREM, S_CARVE, S_LINK, S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic pop;
    logic div_start;
    logic div_step;
    logic chunk_take;
    logic push_rem;
    logic carve_start;
    logic link_step;
    logic release_push;
    logic set_status;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic bad_zero;
    logic bad_over;
    logic is_release;
    logic head_valid;
    logic fit_full;
    logic fit_some;
    logic chunk_ok;
    logic rem_push;
    logic div_done;
    logic link_last;
    logic carve_multi;
  } sts_t;
endpackage
`default_nettype wire

/* design/segregated_free_list_allocator_unit.sv */
// a release or an error goes from decode straight to done; a hit passes through pop
// a refill runs decode, then divide or a chunk take (with the old remainder pushed
// when it fits a class), then carve, and link steps when more than one block is carved
// one request at a time; the next request is taken only once the result has been
// accepted by the receiver
// synchronous active-high reset empties all lists and clears the arena pointers
`default_nettype none
module segregated_free_list_allocator_unit import sfla_pkg::*; #(
  parameter int GRAIN_BYTES = 8,
  parameter int MAX_BLOCK_BYTES = 128,
  parameter int CLASS_COUNT = 16,
  parameter int REFILL_BATCH = 20,
  parameter int ARENA_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [9:0]  request_bytes,
  input  wire logic [15:0] block_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      granted_address,
  output logic [1:0]       status
);
  cmd_t cmd;
  sts_t sts;

  sfla_control u_ctl (.clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd);

  sfla_datapath #(.GRAIN_BYTES(GRAIN_BYTES), .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES),
    .CLASS_COUNT(CLASS_COUNT), .REFILL_BATCH(REFILL_BATCH),
    .ARENA_BYTES(ARENA_BYTES)) u_dp (.clk, .rst, .cmd, .sts, .op, .request_bytes,
    .block_address, .granted_address, .status);
endmodule
`default_nettype wire

/* design/sfla_datapath.sv */
`default_nettype none
module sfla_datapath import sfla_pkg::*; #(
  parameter int GRAIN_BYTES = 8,
  parameter int MAX_BLOCK_BYTES = 128,
  parameter int CLASS_COUNT = 16,
  parameter int REFILL_BATCH = 20,
  parameter int ARENA_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic        op,
  input  wire logic [9:0]  request_bytes,
  input  wire logic [15:0] block_address,
  output logic [15:0]      granted_address,
  output logic [1:0]       status
);
  localparam int GSH = $clog2(GRAIN_BYTES);
  localparam int LINK_DEPTH = ARENA_BYTES / GRAIN_BYTES;
  localparam int LW = $clog2(LINK_DEPTH);
  localparam int CW = $clog2(CLASS_COUNT);
  localparam int BW = $clog2(REFILL_BATCH + 1);
  localparam logic [AW-1:0] ARENA = AW'(ARENA_BYTES);

  logic        op_q;
  logic [9:0]  n_q;
  logic [15:0] addr_q;
  logic [AW-1:0] heads [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] hvalid;
  logic [AW:0] links [LINK_DEPTH];
  logic [AW:0] link_rd;
  logic [AW-1:0] cstart, cend, atop, tot_obt;
  logic [AW-1:0] r, tot, avail, apply, rem, cur;
  logic [BW-1:0] cnt, idx, dcnt;
  logic [CW-1:0] cls;
  logic [10:0] rnd;
  logic [AW-1:0] wr_data;
  logic wr_valid, wr_en;
  logic [LW-1:0] wr_slot;

  assign rnd = (11'(n_q) + 11'(GRAIN_BYTES - 1)) >> GSH;
  assign r = AW'(rnd) << GSH;
  assign cls = CW'(rnd - 11'd1);
  assign tot = AW'(r * REFILL_BATCH);
  assign avail = (cend >= cstart) ? cend - cstart : '0;
  assign apply = AW'(2 * tot) +
    ((((tot_obt >> 4) + AW'(GRAIN_BYTES - 1)) >> GSH) << GSH);

  assign sts.bad_zero = (n_q == '0);
  assign sts.bad_over = (11'(n_q) > 11'(MAX_BLOCK_BYTES)) ||
    (rnd - 11'd1 >= 11'(CLASS_COUNT));
  assign sts.is_release = op_q;
  assign sts.head_valid = hvalid[cls];
  assign sts.fit_full = avail >= tot;
  assign sts.fit_some = avail >= r;
  assign sts.chunk_ok = (atop <= ARENA) && (apply <= ARENA - atop);
  assign sts.rem_push = (avail != '0) && ((avail >> GSH) >= 1) &&
    ((avail >> GSH) - 1 < AW'(CLASS_COUNT));
  assign sts.div_done = (rem < r) || (dcnt == BW'(REFILL_BATCH));
  assign sts.link_last = (idx + 1'b1 >= cnt);
  assign sts.carve_multi = (cnt > BW'(1));

  // write port of the link memory
  always_comb begin
    wr_en = 1'b0; wr_slot = '0; wr_data = '0; wr_valid = 1'b0;
    if (cmd.release_push) begin
      wr_en = 1'b1; wr_slot = LW'(addr_q >> GSH);
      wr_data = heads[cls]; wr_valid = hvalid[cls];
    end else if (cmd.push_rem) begin
      wr_en = 1'b1; wr_slot = LW'(cstart >> GSH);
      wr_data = heads[CW'((avail >> GSH) - 1)];
      wr_valid = hvalid[CW'((avail >> GSH) - 1)];
    end else if (cmd.link_step) begin
      wr_en = 1'b1; wr_slot = LW'(cur >> GSH);
      wr_data = sts.link_last ? '0 : cur + r; wr_valid = !sts.link_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) links[wr_slot] <= {wr_valid, wr_data};
    link_rd <= links[LW'(heads[cls] >> GSH)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0; cstart <= '0; cend <= '0; atop <= '0; tot_obt <= '0;
    end else begin
      if (cmd.latch) begin
        op_q <= op; n_q <= request_bytes; addr_q <= block_address;
        granted_address <= '0;
      end
      if (cmd.set_status) begin
        status <= cmd.status;
        if (cmd.status != ST_OK) granted_address <= '0;
      end
      if (cmd.release_push) begin
        heads[cls] <= AW'(addr_q); hvalid[cls] <= 1'b1;
      end
      if (cmd.push_rem) begin
        heads[CW'((avail >> GSH) - 1)] <= cstart;
        hvalid[CW'((avail >> GSH) - 1)] <= 1'b1;
      end
      if (cmd.pop) begin
        granted_address <= heads[cls][15:0];
        heads[cls] <= link_rd[AW-1:0]; hvalid[cls] <= link_rd[AW];
      end
      if (cmd.chunk_take) begin
        cstart <= atop; cend <= atop + apply; atop <= atop + apply;
        tot_obt <= tot_obt + apply; cnt <= BW'(REFILL_BATCH);
      end
      // repeated subtraction for avail / r, capped at batch size
      if (cmd.div_start) begin
        rem <= avail; dcnt <= '0;
        if (avail >= tot) cnt <= BW'(REFILL_BATCH);
      end else if (cmd.div_step) begin
        if (!sts.div_done) begin
          rem <= rem - r; dcnt <= dcnt + 1'b1;
        end else if (!sts.fit_full) cnt <= dcnt;
      end
      if (cmd.carve_start) begin
        granted_address <= cstart[15:0];
        cstart <= cstart + AW'(cnt * r);
        cur <= cstart + r; idx <= BW'(1);
        if (cnt > BW'(1)) begin
          heads[cls] <= cstart + r; hvalid[cls] <= 1'b1;
        end
      end
      if (cmd.link_step) begin
        cur <= cur + r; idx <= idx + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* design/sfla_control.sv */
`default_nettype none
module sfla_control import sfla_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state, state_next;
  logic ov, ov_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ov <= 1'b0;
    end else begin
      state <= state_next; ov <= ov_next;
    end
  end

  always_comb begin
    cmd = '0; state_next = state; ov_next = ov;
    in_stall = (state != S_IDLE) || ov;
    out_valid = ov;
    if (ov && !out_stall) ov_next = 1'b0;
    case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.latch = 1'b1; state_next = S_DECODE;
      end
      S_DECODE: begin
        cmd.set_status = 1'b1;
        if (sts.bad_zero) begin cmd.status = ST_ZERO; state_next = S_DONE; end
        else if (sts.bad_over) begin cmd.status = ST_OVERSIZE; state_next = S_DONE; end
        else if (sts.is_release) begin cmd.release_push = 1'b1; state_next = S_DONE; end
        else if (sts.head_valid) state_next = S_POP;
        else if (sts.fit_some) begin cmd.div_start = 1'b1; state_next = S_DIV; end
        else if (!sts.chunk_ok) begin cmd.status = ST_EXHAUSTED; state_next = S_DONE; end
        else if (sts.rem_push) state_next = S_PUSHREM;
        else begin cmd.chunk_take = 1'b1; state_next = S_CARVE; end
      end
      S_POP: begin cmd.pop = 1'b1; state_next = S_DONE; end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = S_CARVE;
      end
      S_PUSHREM: begin cmd.push_rem = 1'b1; cmd.chunk_take = 1'b1; state_next = S_CARVE; end
      S_CARVE: begin
        cmd.carve_start = 1'b1;
        state_next = sts.carve_multi ? S_LINK : S_DONE;
      end
      // one carved block linked per cycle, the last one ends the list
      S_LINK: begin
        cmd.link_step = 1'b1;
        if (sts.link_last) state_next = S_DONE;
      end
      S_DONE: begin state_next = S_IDLE; ov_next = 1'b1; end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* design/sfla_checker.sv */
`default_nettype none
module sfla_checker import sfla_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [15:0] granted_address,
  input wire logic [1:0] status
);
  a_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> granted_address == 16'd0) else $error("grant on error");
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)) else $error("result dropped");
  a_acc: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid) else $error("result without processing");
endmodule
bind segregated_free_list_allocator_unit sfla_checker u_chk (.clk, .rst, .in_valid,
  .in_stall, .out_valid, .out_stall, .granted_address, .status);
`default_nettype wire

/* bench/segregated_free_list_allocator_unit_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module segregated_free_list_allocator_unit_tb;
  import sfla_pkg::*;

  localparam int GRAIN = 8;
  localparam int MAX_BYTES = 128;
  localparam int CLASSES = 16;
  localparam int BATCH = 20;
  localparam int ARENA = 65536;
  localparam int SLOTS = ARENA / GRAIN;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  typedef struct {
    logic op;
    logic [9:0] bytes;
    logic [15:0] addr;
    bit typed;
    logic [15:0] want_addr;
    logic [1:0] want_status;
  } row_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0] status;
  } grant_t;

  typedef struct {
    logic [15:0] addr;
    int bytes;
  } live_t;

  logic clk, rst;
  logic in_valid, in_stall, op, out_valid, out_stall;
  logic [9:0] request_bytes;
  logic [15:0] block_address, granted_address;
  logic [1:0] status;

  // allocator mirror
  logic [15:0] head_addr[CLASSES];
  bit head_ok[CLASSES];
  logic [15:0] link_addr[SLOTS];
  bit link_ok[SLOTS];
  int carve_lo, carve_hi, top_ptr, obtained;

  grant_t grant_q[$];
  live_t live_blocks[$];
  int errors = 0;
  bit quiet = 0;
  row_t rows[$];

  segregated_free_list_allocator_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .request_bytes(request_bytes), .block_address(block_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .granted_address(granted_address), .status(status)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("segregated_free_list_allocator_unit_tb: done, errors");
    $finish;
  end

  function automatic int slot_of(int a);
    return (a / GRAIN) % SLOTS;
  endfunction

  function automatic void push_free(int cls, int a);
    int s;
    s = slot_of(a);
    link_addr[s] = head_addr[cls];
    link_ok[s] = head_ok[cls];
    head_addr[cls] = a[15:0];
    head_ok[cls] = 1;
  endfunction

  function automatic grant_t allocate_predict(logic o, int n, int a);
    grant_t g;
    int r, cls, s, avail, tot, cnt, apply, rc, base;
    g = '{addr: 16'd0, status: ST_OK};
    if (n == 0) begin
      g.status = ST_ZERO;
      return g;
    end
    if (n > MAX_BYTES) begin
      g.status = ST_OVERSIZE;
      return g;
    end
    r = ((n + GRAIN - 1) / GRAIN) * GRAIN;
    cls = r / GRAIN - 1;
    if (cls >= CLASSES) begin
      g.status = ST_OVERSIZE;
    end else if (o == OP_FREE) begin
      push_free(cls, a);
    end else if (head_ok[cls]) begin
      s = slot_of(head_addr[cls]);
      g.addr = head_addr[cls];
      head_addr[cls] = link_addr[s];
      head_ok[cls] = link_ok[s];
    end else begin
      avail = (carve_hi >= carve_lo) ? carve_hi - carve_lo : 0;
      tot = r * BATCH;
      if (avail >= tot) begin
        cnt = BATCH;
      end else if (avail >= r) begin
        cnt = avail / r;
      end else begin
        apply = 2 * tot + (((obtained >> 4) + GRAIN - 1) / GRAIN) * GRAIN;
        if (top_ptr > ARENA || apply > ARENA - top_ptr) begin
          g.status = ST_EXHAUSTED;
          return g;
        end
        if (avail > 0) begin
          rc = avail / GRAIN;
          if (rc >= 1 && rc - 1 < CLASSES) push_free(rc - 1, carve_lo);
        end
        carve_lo = top_ptr;
        carve_hi = top_ptr + apply;
        top_ptr += apply;
        obtained += apply;
        cnt = BATCH;
      end
      base = carve_lo;
      carve_lo += cnt * r;
      if (cnt > 1) begin
        head_addr[cls] = 16'(base + r);
        head_ok[cls] = 1;
        for (int i = 1; i < cnt; i++) begin
          s = slot_of(base + i * r);
          link_addr[s] = (i + 1 < cnt) ? 16'(base + (i + 1) * r) : 16'd0;
          link_ok[s] = (i + 1 < cnt);
        end
      end
      g.addr = base[15:0];
    end
    return g;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic issue(row_t rw);
    grant_t g;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    op = rw.op;
    request_bytes = rw.bytes;
    block_address = rw.addr;
    in_valid = 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = allocate_predict(rw.op, rw.bytes, rw.addr);
    if (rw.typed) grant_q.push_back('{addr: rw.want_addr, status: rw.want_status});
    else grant_q.push_back(g);
    if (rw.op == OP_ALLOC && g.status == ST_OK && rw.bytes != 0)
      live_blocks.push_back('{addr: g.addr, bytes: rw.bytes});
    @(negedge clk);
  endtask

  // receiver backpressure
  initial begin
    int p;
    out_stall = 0;
    forever begin
      @(negedge clk);
      p = $urandom_range(0, 99);
      if (quiet || p < 60) out_stall = 0;
      else if (p < 95) out_stall = 1;
      else begin
        out_stall = 1;
        repeat ($urandom_range(5, 25)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    grant_t e;
    if (!rst && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result: granted_address %0h status %0d",
               granted_address, status);
        errors++;
      end else begin
        e = grant_q.pop_front();
        if (granted_address !== e.addr) begin
          $error("granted_address: expected %0h, got %0h", e.addr, granted_address);
          errors++;
        end
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t rw;
    live_t lb;
    int p, k, cls;
    rst = 1;
    in_valid = 0;
    op = OP_ALLOC;
    request_bytes = 0;
    block_address = 0;
    for (int i = 0; i < CLASSES; i++) begin
      head_addr[i] = 0;
      head_ok[i] = 0;
    end
    carve_lo = 0;
    carve_hi = 0;
    top_ptr = 0;
    obtained = 0;

    // directed table
    rows.push_back('{OP_ALLOC, 10'd0, 16'h0000, 1, 16'h0000, ST_ZERO});
    rows.push_back('{OP_FREE, 10'd0, 16'hFFFF, 1, 16'h0000, ST_ZERO});
    rows.push_back('{OP_ALLOC, 10'd129, 16'h0000, 1, 16'h0000, ST_OVERSIZE});
    rows.push_back('{OP_ALLOC, 10'd1023, 16'hFFFF, 1, 16'h0000, ST_OVERSIZE});
    rows.push_back('{OP_FREE, 10'd1023, 16'hFFFF, 1, 16'h0000, ST_OVERSIZE});
    rows.push_back('{OP_ALLOC, 10'd1, 16'h0000, 1, 16'h0000, ST_OK});
    rows.push_back('{OP_ALLOC, 10'd8, 16'h0000, 0, 16'h0, ST_OK});
    rows.push_back('{OP_ALLOC, 10'd128, 16'h0000, 0, 16'h0, ST_OK});
    rows.push_back('{OP_ALLOC, 10'd128, 16'h0000, 0, 16'h0, ST_OK});
    rows.push_back('{OP_ALLOC, 10'd120, 16'h0000, 0, 16'h0, ST_OK});
    rows.push_back('{OP_FREE, 10'd8, 16'h0000, 0, 16'h0, ST_OK});
    rows.push_back('{OP_ALLOC, 10'd5, 16'h0000, 0, 16'h0, ST_OK});
    rows.push_back('{OP_FREE, 10'd16, 16'hFFFF, 0, 16'h0, ST_OK});
    rows.push_back('{OP_ALLOC, 10'd9, 16'h0000, 0, 16'h0, ST_OK});
    rows.push_back('{OP_ALLOC, 10'd64, 16'h0000, 0, 16'h0, ST_OK});
    rows.push_back('{OP_FREE, 10'd128, 16'h0007, 0, 16'h0, ST_OK});
    rows.push_back('{OP_ALLOC, 10'd127, 16'h0000, 0, 16'h0, ST_OK});
    // repeated large misses walk the refill path to the remainder push
    for (int i = 0; i < 6; i++)
      rows.push_back('{OP_ALLOC, 10'(121 - 8 * i), 16'h0000, 0, 16'h0, ST_OK});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (rows[i]) issue(rows[i]);

    for (int n = 0; n < 550; n++) begin
      if (n % 90 == 0) quiet = ($urandom_range(0, 3) == 0);
      p = $urandom_range(0, 99);
      rw = '{OP_ALLOC, 10'd0, 16'h0, 0, 16'h0, ST_OK};
      rw.addr = 16'($urandom_range(0, 65535));
      if (p < 55) begin
        // small sizes most of the time so lists see many hits
        if ($urandom_range(0, 3) != 0) rw.bytes = 10'($urandom_range(1, 32));
        else rw.bytes = 10'($urandom_range(1, MAX_BYTES));
      end else if (p < 85 && live_blocks.size() > 0) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        lb = live_blocks[k];
        live_blocks.delete(k);
        cls = (lb.bytes + GRAIN - 1) / GRAIN - 1;
        rw.op = OP_FREE;
        rw.bytes = 10'(cls * GRAIN + $urandom_range(1, GRAIN));
        rw.addr = lb.addr;
      end else begin
        rw.op = logic'($urandom_range(0, 1));
        k = $urandom_range(0, 2);
        if (k == 0) rw.bytes = 10'd0;
        else if (k == 1) rw.bytes = 10'($urandom_range(MAX_BYTES + 1, 1023));
        else begin
          // foreign release at any address
          rw.op = OP_FREE;
          rw.bytes = 10'($urandom_range(1, MAX_BYTES));
        end
      end
      issue(rw);
    end
    in_valid = 0;
    quiet = 0;

    while (grant_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("segregated_free_list_allocator_unit_tb: done, clean");
    end else begin
      $display("segregated_free_list_allocator_unit_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
